/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl; define NO_ASSERTIONS to drop them
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// antecedent at an edge implies consequent at the same edge
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/u2a_pkg.sv */
// ----------------------------------------------------------------------------
// u2a_pkg
// types, codes and the latin-1 folding table for the utf-8 folder
// ----------------------------------------------------------------------------
package u2a_pkg;

    localparam int CharW   = 8;
    localparam int StatusW = 3;
    localparam int CpW     = 21;

    typedef logic [CharW-1:0]   char_t;
    typedef logic [StatusW-1:0] status_t;
    typedef logic [CpW-1:0]     cp_t;

    // status codes
    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_STRAY   = 3'd1;
    localparam status_t ST_LEAD    = 3'd2;
    localparam status_t ST_BROKEN  = 3'd3;
    localparam status_t ST_TRUNC   = 3'd4;
    localparam status_t ST_INVALID = 3'd5;

    // input commands
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_EOS  = 1'b1;

    // configuration register indexes
    localparam logic REG_BAD_CHAR      = 1'b0;
    localparam logic REG_UNMAPPED_CHAR = 1'b1;

    localparam char_t BAD_CHAR_RESET      = 8'd255;
    localparam char_t UNMAPPED_CHAR_RESET = 8'd32;
    localparam char_t DQUOTE              = 8'h22;
    localparam char_t SQUOTE              = 8'h27;

    // latin-1 folding table, control range and ascii fold to zero
    function automatic char_t fold_latin1(input char_t c);
        char_t r;
        case (c) inside
            [8'h00:8'h9F]: r = 8'd0;
            8'hA2:         r = 8'd99;
            8'hA3, 8'hA5:  r = 8'd36;
            8'hA6:         r = 8'd124;
            8'hA7:         r = 8'd42;
            8'hAB, 8'hBB:  r = 8'd34;
            8'hB1:         r = 8'd43;
            8'hB4:         r = 8'd39;
            8'hB5:         r = 8'd117;
            [8'hC0:8'hC6]: r = 8'd65;
            8'hC7:         r = 8'd67;
            [8'hC8:8'hCB]: r = 8'd69;
            [8'hCC:8'hCF]: r = 8'd73;
            8'hD0:         r = 8'd68;
            8'hD1:         r = 8'd78;
            [8'hD2:8'hD6]: r = 8'd79;
            8'hD7:         r = 8'd128;
            8'hD8:         r = 8'd79;
            [8'hD9:8'hDC]: r = 8'd85;
            8'hDD:         r = 8'd89;
            8'hDF:         r = 8'd115;
            [8'hE0:8'hE6]: r = 8'd97;
            8'hE7:         r = 8'd99;
            [8'hE8:8'hEB]: r = 8'd101;
            [8'hEC:8'hEF]: r = 8'd105;
            8'hF0:         r = 8'd111;
            8'hF1:         r = 8'd118;
            [8'hF2:8'hF6]: r = 8'd111;
            8'hF8:         r = 8'd111;
            [8'hF9:8'hFC]: r = 8'd117;
            8'hFD, 8'hFF:  r = 8'd121;
            default:       r = 8'd32;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/utf8_to_ascii_folder.sv */
// ----------------------------------------------------------------------------
// utf8_to_ascii_folder
// decodes a utf-8 byte stream and folds each code point to a single byte
// ----------------------------------------------------------------------------
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-----------------------
// in       | in        | in_valid / in_stall   | cmd, data_byte
// out      | out       | out_valid / out_stall | out_char, status
// cfg      | in        | cfg_wr_en             | cfg_index, cfg_data
//
// one byte per cycle sustained while in_stall is low; a result goes through
// the input register, then the result register. decode state updates in one pass.
// a stalled output holds its result while bytes that give no result keep
// flowing; in_stall rises only when both registers are full and the held
// byte would give a result.
// reset clears the decode state and loads bad_char 0xff, unmapped_char 0x20.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8_to_ascii_folder
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                cmd,
    input  u2a_pkg::char_t      data_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output u2a_pkg::char_t      out_char,
    output u2a_pkg::status_t    status,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  u2a_pkg::char_t      cfg_data
);
    import u2a_pkg::*;

    logic       s1_valid_reg;
    logic       s1_cmd_reg;
    char_t      s1_byte_reg;
    logic [1:0] rem_reg, rem_next;
    logic [1:0] len_reg, len_next;
    cp_t        acc_reg, acc_next;
    char_t      bad_char_reg;
    char_t      unmapped_char_reg;
    logic       out_valid_reg;
    char_t      out_char_reg, out_char_next;
    status_t    status_reg, status_next;

    logic  emit;
    logic  out_free;
    logic  s1_go;
    logic  in_xfer;
    cp_t   cp_done;
    cp_t   min_cp;
    logic  cp_bad;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && (out_free || !emit);
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_xfer  = in_valid && !in_stall;

    // code point once the last continuation arrives
    assign cp_done = {acc_reg[CpW-7:0], s1_byte_reg[5:0]};

    always_comb
    begin
        case (len_reg)
            2'd1:    min_cp = 21'h00080;
            2'd2:    min_cp = 21'h00800;
            default: min_cp = 21'h10000;
        endcase
    end

    assign cp_bad = (cp_done < min_cp) || (cp_done > 21'h10FFFF)
                 || (cp_done >= 21'h00D800 && cp_done <= 21'h00DFFF);

    always_comb
    begin
        emit          = 1'b0;
        out_char_next = bad_char_reg;
        status_next   = ST_OK;
        rem_next      = rem_reg;
        len_next      = len_reg;
        acc_next      = acc_reg;
        if (s1_cmd_reg == CMD_EOS)
        begin
            rem_next = 2'd0;
            len_next = 2'd0;
            acc_next = '0;
            if (rem_reg != 2'd0)
            begin
                emit        = 1'b1;
                status_next = ST_TRUNC;
            end
        end
        else if (rem_reg == 2'd0)
        begin
            if (s1_byte_reg < 8'h80)
            begin
                emit          = 1'b1;
                out_char_next = s1_byte_reg;
            end
            else if (s1_byte_reg < 8'hC0)
            begin
                emit        = 1'b1;
                status_next = ST_STRAY;
            end
            else if (s1_byte_reg >= 8'hC2 && s1_byte_reg <= 8'hDF)
            begin
                rem_next = 2'd1;
                len_next = 2'd1;
                acc_next = {16'd0, s1_byte_reg[4:0]};
            end
            else if (s1_byte_reg >= 8'hE0 && s1_byte_reg <= 8'hEF)
            begin
                rem_next = 2'd2;
                len_next = 2'd2;
                acc_next = {17'd0, s1_byte_reg[3:0]};
            end
            else if (s1_byte_reg >= 8'hF0 && s1_byte_reg <= 8'hF4)
            begin
                rem_next = 2'd3;
                len_next = 2'd3;
                acc_next = {18'd0, s1_byte_reg[2:0]};
            end
            else
            begin
                emit        = 1'b1;
                status_next = ST_LEAD;
            end
        end
        else if (s1_byte_reg[7:6] != 2'b10)
        begin
            emit        = 1'b1;
            status_next = ST_BROKEN;
            rem_next    = 2'd0;
            len_next    = 2'd0;
            acc_next    = '0;
        end
        else if (rem_reg != 2'd1)
        begin
            acc_next = cp_done;
            rem_next = rem_reg - 2'd1;
        end
        else
        begin
            // sequence complete
            emit     = 1'b1;
            rem_next = 2'd0;
            len_next = 2'd0;
            acc_next = '0;
            if (cp_bad)
                status_next = ST_INVALID;
            else if (cp_done == 21'd8249 || cp_done == 21'd8250
                  || cp_done == 21'd8220 || cp_done == 21'd8221
                  || cp_done == 21'd8222 || cp_done == 21'd8218)
                out_char_next = DQUOTE;
            else if (cp_done == 21'd8216 || cp_done == 21'd8217)
                out_char_next = SQUOTE;
            else if (cp_done < 21'd256)
                out_char_next = fold_latin1(cp_done[7:0]);
            else
                out_char_next = unmapped_char_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            rem_reg           <= 2'd0;
            len_reg           <= 2'd0;
            acc_reg           <= '0;
            bad_char_reg      <= BAD_CHAR_RESET;
            unmapped_char_reg <= UNMAPPED_CHAR_RESET;
        end
        else
        begin
            if (in_xfer)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;

            if (s1_go && emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (s1_go)
            begin
                rem_reg <= rem_next;
                len_reg <= len_next;
                acc_reg <= acc_next;
            end

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_BAD_CHAR:      bad_char_reg      <= cfg_data;
                    REG_UNMAPPED_CHAR: unmapped_char_reg <= cfg_data;
                    default:           bad_char_reg      <= bad_char_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_cmd_reg  <= cmd;
            s1_byte_reg <= data_byte;
        end
        if (s1_go && emit)
        begin
            out_char_reg <= out_char_next;
            status_reg   <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign status    = status_reg;

    `ASSERT_IMPLIES(a_err_uses_bad_char, clk, rst_n,
        out_valid_reg && status_reg != ST_OK, out_char_reg == bad_char_reg)
    `ASSERT_IMPLIES(a_status_range, clk, rst_n, out_valid_reg, status_reg <= ST_INVALID)
    `ASSERT_IMPLIES(a_open_seq_consistent, clk, rst_n,
        rem_reg != 2'd0, len_reg != 2'd0 && rem_reg <= len_reg)
    `ASSERT_IMPLIES(a_stall_only_when_full, clk, rst_n,
        in_stall, s1_valid_reg && out_valid_reg && out_stall)

endmodule
